/* hdl/imu_enc_pkg.sv */
// Shared constants, types and character helpers for the IMU sentence encoder.
`default_nettype none

package imu_enc_pkg;

    // Sentence geometry.
    localparam int unsigned SENT_LEN  = 43;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned NUM_WORDS = 6;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned SEQ_W     = 4;
    localparam int unsigned IN_DATA_W = 104;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [7:0]       char_t;

    // Byte positions within one sentence.
    localparam idx_t IDX_HDR_LAST   = idx_t'(6);
    localparam idx_t IDX_WORD_FIRST = idx_t'(7);
    localparam idx_t IDX_WORD_LAST  = idx_t'(36);
    localparam idx_t IDX_ZERO       = idx_t'(37);
    localparam idx_t IDX_SEQ        = idx_t'(38);
    localparam idx_t IDX_STAR       = idx_t'(39);
    localparam idx_t IDX_SUM_HI     = idx_t'(40);
    localparam idx_t IDX_SUM_LO     = idx_t'(41);
    localparam idx_t IDX_LAST       = idx_t'(SENT_LEN - 1);

    // Digit position within a word group; the fifth slot is the comma.
    localparam logic [2:0] DIG_COMMA = 3'd4;

    // ASCII characters used in the sentence.
    localparam char_t CH_DOLLAR = 8'h24;
    localparam char_t CH_COMMA  = 8'h2C;
    localparam char_t CH_STAR   = 8'h2A;
    localparam char_t CH_ZERO   = 8'h30;
    localparam char_t CH_LF     = 8'h0A;
    localparam char_t CH_HEX_AF = 8'h37;

    // Upper-case hex digit for one nibble.
    function automatic char_t hex_char(input logic [3:0] nib);
        if (nib <= 4'd9)
        begin
            return CH_ZERO + {4'h0, nib};
        end
        return CH_HEX_AF + {4'h0, nib};
    endfunction

    // Fixed header text "$GPIMU,".
    function automatic char_t header_char(input logic [2:0] pos);
        char_t c;
        case (pos)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h49;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h55;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/imu_ascii_sentence_encoder.sv */
// Top level of the IMU ASCII sentence encoder.
`default_nettype none

// Each accepted sample becomes one 43-byte sentence "$GPIMU,XXXX,...,0D*CC\n",
// sent one byte per item on the output stream with tlast on the line feed.
// The single byte-wide output register sets the rate. The next sample is
// accepted in the cycle the last byte of the current sentence is issued,
// so with the output always ready sentences follow with no gap. The
// checksum is the XOR of the bytes between '$' and '*', accumulated byte
// by byte as the sentence is sent.
module imu_ascii_sentence_encoder
    import imu_enc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, seq_digit, zero pad
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // text_byte
    output logic [7:0]                m_tdata,
    output logic                      m_tlast
);

    localparam int unsigned WORDS_W = NUM_WORDS * WORD_W;

    // Sample registers and sentence position.
    logic [WORDS_W-1:0] words_reg, words_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    idx_t               idx_reg, idx_next;
    logic [2:0]         dig_reg, dig_next;
    char_t              sum_reg, sum_next;
    logic               busy_reg, busy_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    char_t              out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;

    logic  issue;
    logic  accept;
    logic  in_words;
    char_t cur_char;

    // A byte is issued whenever a sentence is active and the output register frees up.
    assign issue    = busy_reg && (!out_valid_reg || m_tready);
    assign s_tready = !busy_reg || (issue && (idx_reg == IDX_LAST));
    assign accept   = s_tvalid && s_tready;
    assign in_words = (idx_reg inside {[IDX_WORD_FIRST:IDX_WORD_LAST]});

    // Character for the current sentence position.
    always_comb
    begin
        if (idx_reg <= IDX_HDR_LAST)
        begin
            cur_char = header_char(idx_reg[2:0]);
        end
        else if (in_words)
        begin
            cur_char = (dig_reg == DIG_COMMA) ? CH_COMMA
                                               : hex_char(words_reg[WORDS_W-1 -: 4]);
        end
        else if (idx_reg == IDX_ZERO)
        begin
            cur_char = CH_ZERO;
        end
        else if (idx_reg == IDX_SEQ)
        begin
            cur_char = CH_ZERO + {4'h0, seq_reg};
        end
        else if (idx_reg == IDX_STAR)
        begin
            cur_char = CH_STAR;
        end
        else if (idx_reg == IDX_SUM_HI)
        begin
            cur_char = hex_char(sum_reg[7:4]);
        end
        else if (idx_reg == IDX_SUM_LO)
        begin
            cur_char = hex_char(sum_reg[3:0]);
        end
        else
        begin
            cur_char = CH_LF;
        end
    end

    // Sentence sequencing, digit shifting and checksum accumulation.
    always_comb
    begin
        words_next = words_reg;
        seq_next   = seq_reg;
        idx_next   = idx_reg;
        dig_next   = dig_reg;
        sum_next   = sum_reg;
        busy_next  = busy_reg;

        if (issue)
        begin
            idx_next = idx_reg + idx_t'(1);
            if (idx_reg == IDX_LAST)
            begin
                busy_next = 1'b0;
            end
            if (in_words)
            begin
                if (dig_reg == DIG_COMMA)
                begin
                    dig_next = 3'd0;
                end
                else
                begin
                    dig_next   = dig_reg + 3'd1;
                    words_next = {words_reg[WORDS_W-5:0], 4'h0};
                end
            end
            if ((idx_reg != 6'd0) && (idx_reg <= IDX_SEQ))
            begin
                sum_next = sum_reg ^ cur_char;
            end
        end

        // A new sample starts a fresh sentence; gyro_x goes out first.
        if (accept)
        begin
            words_next = {s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                          s_tdata[63:48], s_tdata[79:64], s_tdata[95:80]};
            seq_next   = s_tdata[99:96];
            idx_next   = idx_t'(0);
            dig_next   = 3'd0;
            sum_next   = 8'h00;
            busy_next  = 1'b1;
        end
    end

    // Output register load.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_char;
            out_last_next  = (idx_reg == IDX_LAST);
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= idx_t'(0);
            dig_reg       <= 3'd0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            dig_reg       <= dig_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        words_reg    <= words_next;
        seq_reg      <= seq_next;
        sum_reg      <= sum_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the IMU ASCII sentence encoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_enc_pkg::*;

    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned STUCK_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned RANDOM_ITEMS = 170;
    localparam char_t       CHAR_A       = 8'h41;

    // One sample as it travels on s_tdata, last field (gyro_x) in the lowest bits.
    typedef struct packed {
        logic [3:0]  pad;
        logic [3:0]  seq_digit;
        logic [15:0] accel_z;
        logic [15:0] accel_y;
        logic [15:0] accel_x;
        logic [15:0] gyro_z;
        logic [15:0] gyro_y;
        logic [15:0] gyro_x;
    } imu_sample_t;

    // One character of a sentence as it leaves the block.
    typedef struct packed {
        char_t text_byte;
        logic  last_byte;
    } sentence_char_t;

    // Ways the output side accepts characters.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;

    sentence_char_t expected_chars [$];
    sentence_char_t want;
    int             mismatches = 0;
    int             burst_left = 0;
    bit             hold_request = 1'b0;
    int             stuck_cycles = 0;

    imu_ascii_sentence_encoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock, 20 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Upper-case hex digit for one nibble.
    function automatic char_t ascii_hex(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CH_ZERO + {4'h0, nib};
        end
        return CHAR_A + {4'h0, nib} - 8'd10;
    endfunction

    // Builds the sentence for one sample and queues its characters.
    function automatic void predict_sentence(input imu_sample_t smp);
        string          header;
        logic [15:0]    words [NUM_WORDS];
        char_t          line [$];
        char_t          sum;
        sentence_char_t item;
        header = "$GPIMU,";
        words  = '{smp.gyro_x, smp.gyro_y, smp.gyro_z,
                   smp.accel_x, smp.accel_y, smp.accel_z};
        sum    = '0;
        for (int i = 0; i < header.len(); i++)
        begin
            line.push_back(header[i]);
        end
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            for (int d = 3; d >= 0; d--)
            begin
                line.push_back(ascii_hex(words[w][d*4 +: 4]));
            end
            line.push_back(CH_COMMA);
        end
        line.push_back(CH_ZERO);
        line.push_back(CH_ZERO + {4'h0, smp.seq_digit});
        // The checksum skips the leading dollar sign and stops before the star.
        for (int i = 1; i < line.size(); i++)
        begin
            sum ^= line[i];
        end
        line.push_back(CH_STAR);
        line.push_back(ascii_hex(sum[7:4]));
        line.push_back(ascii_hex(sum[3:0]));
        line.push_back(CH_LF);
        foreach (line[i])
        begin
            item.text_byte = line[i];
            item.last_byte = (i == line.size() - 1);
            expected_chars.push_back(item);
        end
    endfunction

    function automatic imu_sample_t make_sample(input logic [15:0] gx, input logic [15:0] gy,
                                                input logic [15:0] gz, input logic [15:0] ax,
                                                input logic [15:0] ay, input logic [15:0] az,
                                                input logic [3:0] seq);
        imu_sample_t smp;
        smp = '{pad: 4'h0, seq_digit: seq, accel_z: az, accel_y: ay, accel_x: ax,
                gyro_z: gz, gyro_y: gy, gyro_x: gx};
        return smp;
    endfunction

    // Random word with a bias toward the all-zero and all-one patterns.
    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic imu_sample_t rand_sample();
        logic [3:0] seq;
        seq = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(10, 15))
                                          : 4'($urandom_range(0, 9));
        return make_sample(rand_word(), rand_word(), rand_word(),
                           rand_word(), rand_word(), rand_word(), seq);
    endfunction

    // Offers one sample; bursts of random length are separated by random gaps.
    task automatic send_sample(input imu_sample_t smp);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 15);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_tdata  <= smp;
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        predict_sentence(smp);
        burst_left--;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
        end
    endtask

    // Withdraws the input at the end of a test.
    task automatic close_burst();
        if (burst_left != 0)
        begin
            s_tvalid   <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Starts a burst of back-to-back items with no gap on the input side.
    task automatic start_burst(input int n);
        close_burst();
        @(posedge clk);
        burst_left = n;
    endtask

    // Extreme words and every hex digit in the words.
    task automatic test_field_extremes();
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000,
                                16'h0000, 16'h0000, 16'h0000, 4'd0));
        send_sample(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd9));
        send_sample(make_sample(16'h0123, 16'h4567, 16'h89AB,
                                16'hCDEF, 16'hFEDC, 16'hBA98, 4'd5));
        send_sample(make_sample(16'h7654, 16'h3210, 16'hEDCB,
                                16'hA987, 16'h1357, 16'h9BDF, 4'd3));
        send_sample(make_sample(16'hA5A5, 16'h5A5A, 16'hA5A5,
                                16'h5A5A, 16'hA5A5, 16'h5A5A, 4'd1));
        send_sample(make_sample(16'h8000, 16'h0001, 16'h7FFF,
                                16'hFFFE, 16'h00FF, 16'hFF00, 4'd8));
        close_burst();
    endtask

    // Sequence digits ten to fifteen print as the characters after '9'.
    task automatic test_seq_above_nine();
        for (int s = 10; s <= 15; s++)
        begin
            send_sample(make_sample(rand_word(), rand_word(), rand_word(),
                                    rand_word(), rand_word(), rand_word(), 4'(s)));
        end
        close_burst();
    endtask

    // Sentences back to back with no gap on the input side.
    task automatic test_full_rate();
        start_burst(10);
        for (int i = 0; i < 10; i++)
        begin
            send_sample(rand_sample());
        end
        close_burst();
    endtask

    // The output holds off for a long stretch while samples keep coming.
    task automatic test_output_hold();
        start_burst(6);
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            send_sample(rand_sample());
        end
        close_burst();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_sample(rand_sample());
        end
        close_burst();
    endtask

    // Stimulus and end of run.
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_seq_above_nine();
        test_full_rate();
        test_output_hold();
        test_random_traffic();
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_chars.size() == 0)
        begin
            $display("[imu_ascii_sentence_encoder] OK");
        end
        else
        begin
            $display("[imu_ascii_sentence_encoder] ERROR");
        end
        $finish;
    end

    // Output side: random acceptance patterns plus one long hold on request.
    initial
    begin
        rx_mode_t rx_mode;
        int       rx_left;
        int       rx_phase;
        m_tready = 1'b0;
        rx_mode  = RX_ALWAYS;
        rx_left  = 0;
        rx_phase = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(1, 60);
                end
                rx_left--;
                rx_phase++;
                case (rx_mode)
                    RX_ALWAYS:   m_tready <= 1'b1;
                    RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:     m_tready <= (rx_phase % 3 != 0);
                endcase
            end
        end
    end

    // Each accepted character is checked against the oldest one predicted.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected item: text_byte %02h last_byte %0b", m_tdata, m_tlast);
                mismatches++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.text_byte)
                begin
                    $error("text_byte: expected %02h actual %02h", want.text_byte, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last_byte)
                begin
                    $error("last_byte: expected %0b actual %0b", want.last_byte, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if no item moves on either side for too long.
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
            end
        end
        $display("[imu_ascii_sentence_encoder] ERROR");
        $finish;
    end

endmodule

/* imu_ascii_sentence_encoder.f */
hdl/imu_enc_pkg.sv
hdl/imu_ascii_sentence_encoder.sv
tb/sv/tb.sv
